### hw/rtl/pdd_pkg.sv
// Shared types and constants for the differential-drive PID steering block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package pdd_pkg;

    typedef logic signed [15:0] error_t;   // Q8.8 position error
    typedef logic signed [8:0]  speed_t;   // PWM units, signed
    typedef logic        [15:0] gain_t;    // unsigned Q8.8 gain
    typedef logic signed [14:0] integ_t;   // Q7.8 integral, within +-50.0
    typedef logic        [7:0]  top_t;     // full wheel speed
    typedef logic        [15:0] cfg_data_t;

    typedef enum logic [2:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_MAP_PROP_GAIN  = 3'd3,
        REG_MAP_INTEG_GAIN = 3'd4,
        REG_MAP_DERIV_GAIN = 3'd5,
        REG_FOLLOW_MAP     = 3'd6,
        REG_TOP_SPEED      = 3'd7
    } cfg_index_t;

    localparam int INTEG_LIMIT      = 12800;  // 50.0 in Q8.8
    localparam int BIG_ERROR        = 14080;  // 55.0 in Q8.8
    localparam int BIG_ERROR_FLOOR  = -250;

endpackage

`default_nettype wire

### hw/rtl/pdd_sample_if.sv
// Input channel: one control sample (position error and floor speed).
// Depends on pdd_pkg.
`default_nettype none

interface pdd_sample_if;
    logic                  valid;
    logic                  ready;
    pdd_pkg::error_t       position_error;
    pdd_pkg::speed_t       floor_speed;

    modport source (output valid, output position_error, output floor_speed, input ready);
    modport sink   (input valid, input position_error, input floor_speed, output ready);
endinterface

`default_nettype wire

### hw/rtl/pdd_command_if.sv
// Output channel: one pair of wheel speed commands.
// Depends on pdd_pkg.
`default_nettype none

interface pdd_command_if;
    logic                  valid;
    logic                  ready;
    pdd_pkg::speed_t       left_speed;
    pdd_pkg::speed_t       right_speed;

    modport source (output valid, output left_speed, output right_speed, input ready);
    modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

`default_nettype wire

### hw/rtl/pdd_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on pdd_pkg.
`default_nettype none

interface pdd_cfg_if;
    logic                  valid;
    logic                  ready;
    pdd_pkg::cfg_index_t   index;
    pdd_pkg::cfg_data_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/pid_differential_drive.sv
// PID steering for a differential-drive line follower.
// Depends on pdd_pkg, pdd_sample_if, pdd_command_if and pdd_cfg_if.
//
// Usage:
//   sample  - input items: position_error (Q8.8) and floor_speed (PWM units).
//   command - result items: left_speed and right_speed, one per sample.
//   cfg     - register writes (gains, map select, top speed); always ready.
//             Write only while no sample is in flight.
// Pipeline: input register -> three gain products -> sum -> |sum|*100 ->
//   wheel speed result register. One item per cycle sustained while the
//   command channel is ready; the result shows on command from the result register.
// The integral and previous error are updated in the cycle a sample is
//   accepted, so back-to-back samples see each other's state.
// Each stage holds its item while the stage after it is full and stalled;
//   bubbles collapse, so sample.ready stays high until every stage is full
//   behind a stalled command channel.
// Reset clears all config registers, the integral, the previous error and
//   all stage valid flags; nothing is emitted until a sample arrives.
`default_nettype none

module pid_differential_drive (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pdd_sample_if.sink     sample,
    pdd_command_if.source  command,
    pdd_cfg_if.sink        cfg
);

    // ---------------- configuration registers ----------------
    pdd_pkg::gain_t prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    pdd_pkg::gain_t map_prop_gain_reg, map_integ_gain_reg, map_deriv_gain_reg;
    logic           follow_map_reg;
    pdd_pkg::top_t  top_speed_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prop_gain_reg      <= '0;
            integ_gain_reg     <= '0;
            deriv_gain_reg     <= '0;
            map_prop_gain_reg  <= '0;
            map_integ_gain_reg <= '0;
            map_deriv_gain_reg <= '0;
            follow_map_reg     <= 1'b0;
            top_speed_reg      <= '0;
        end
        else if (cfg.valid) begin
            case (cfg.index)
                pdd_pkg::REG_PROP_GAIN:      prop_gain_reg      <= cfg.data;
                pdd_pkg::REG_INTEG_GAIN:     integ_gain_reg     <= cfg.data;
                pdd_pkg::REG_DERIV_GAIN:     deriv_gain_reg     <= cfg.data;
                pdd_pkg::REG_MAP_PROP_GAIN:  map_prop_gain_reg  <= cfg.data;
                pdd_pkg::REG_MAP_INTEG_GAIN: map_integ_gain_reg <= cfg.data;
                pdd_pkg::REG_MAP_DERIV_GAIN: map_deriv_gain_reg <= cfg.data;
                pdd_pkg::REG_FOLLOW_MAP:     follow_map_reg     <= cfg.data[0];
                pdd_pkg::REG_TOP_SPEED:      top_speed_reg      <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // Active gains. User keeps config static while items are in flight; no check.
    pdd_pkg::gain_t kp, ki, kd;
    assign kp = follow_map_reg ? map_prop_gain_reg  : prop_gain_reg;
    assign ki = follow_map_reg ? map_integ_gain_reg : integ_gain_reg;
    assign kd = follow_map_reg ? map_deriv_gain_reg : deriv_gain_reg;

    // ---------------- stage handshake ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_en, s2_en, s3_en, s4_en, out_en;

    assign out_en = !out_valid_reg || command.ready;
    assign s4_en  = !s4_valid_reg  || out_en;
    assign s3_en  = !s3_valid_reg  || s4_en;
    assign s2_en  = !s2_valid_reg  || s3_en;
    assign s1_en  = !s1_valid_reg  || s2_en;

    assign sample.ready = s1_en;

    logic accept;
    assign accept = sample.valid && s1_en;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (s1_en)  s1_valid_reg  <= sample.valid;
            if (s2_en)  s2_valid_reg  <= s1_valid_reg;
            if (s3_en)  s3_valid_reg  <= s2_valid_reg;
            if (s4_en)  s4_valid_reg  <= s3_valid_reg;
            if (out_en) out_valid_reg <= s4_valid_reg;
        end
    end

    // ---------------- controller state (updated on accept) ----------------
    pdd_pkg::integ_t integral_sum_reg, integral_sum_next;
    pdd_pkg::error_t previous_error_reg;

    logic signed [16:0] integ_raw;   // I + e before clamping
    logic signed [16:0] deriv_next;  // e - previous error
    pdd_pkg::speed_t    floor_next;
    logic               big_error;

    assign integ_raw  = 17'(integral_sum_reg) + 17'(sample.position_error);
    assign deriv_next = 17'(sample.position_error) - 17'(previous_error_reg);

    always_comb begin
        if (sample.position_error == '0) begin
            integral_sum_next = '0;
        end
        else if (integ_raw > 17'(pdd_pkg::INTEG_LIMIT)) begin
            integral_sum_next = 15'(pdd_pkg::INTEG_LIMIT);
        end
        else if (integ_raw < -17'(pdd_pkg::INTEG_LIMIT)) begin
            integral_sum_next = -15'(pdd_pkg::INTEG_LIMIT);
        end
        else begin
            integral_sum_next = integ_raw[14:0];
        end
    end

    // Large error forces a reverse-capable floor so the robot can pivot.
    assign big_error  = (sample.position_error >= 16'(pdd_pkg::BIG_ERROR))
                     || (sample.position_error <= -16'(pdd_pkg::BIG_ERROR));
    assign floor_next = big_error ? 9'(pdd_pkg::BIG_ERROR_FLOOR) : sample.floor_speed;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            integral_sum_reg   <= '0;
            previous_error_reg <= '0;
        end
        else if (accept) begin
            integral_sum_reg   <= integral_sum_next;
            previous_error_reg <= sample.position_error;
        end
    end

    // ---------------- stage 1: input register ----------------
    pdd_pkg::error_t    s1_err_reg;
    pdd_pkg::integ_t    s1_integ_reg;
    logic signed [16:0] s1_deriv_reg;
    pdd_pkg::speed_t    s1_floor_reg;

    always_ff @(posedge clk) begin
        if (accept) begin
            s1_err_reg   <= sample.position_error;
            s1_integ_reg <= integral_sum_next;
            s1_deriv_reg <= deriv_next;
            s1_floor_reg <= floor_next;
        end
    end

    // ---------------- stage 2: gain products (Q16.16) ----------------
    logic signed [32:0] prod_p_next;
    logic signed [31:0] prod_i_next;
    logic signed [33:0] prod_d_next;

    assign prod_p_next = 33'($signed({1'b0, kp})) * 33'(s1_err_reg);
    assign prod_i_next = 32'($signed({1'b0, ki})) * 32'(s1_integ_reg);
    assign prod_d_next = 34'($signed({1'b0, kd})) * 34'(s1_deriv_reg);

    logic signed [32:0] s2_prod_p_reg;
    logic signed [31:0] s2_prod_i_reg;
    logic signed [33:0] s2_prod_d_reg;
    pdd_pkg::speed_t    s2_floor_reg;

    always_ff @(posedge clk) begin
        if (s2_en && s1_valid_reg) begin
            s2_prod_p_reg <= prod_p_next;
            s2_prod_i_reg <= prod_i_next;
            s2_prod_d_reg <= prod_d_next;
            s2_floor_reg  <= s1_floor_reg;
        end
    end

    // ---------------- stage 3: PID sum (before the x100 scale) ----------------
    logic signed [35:0] sum_next;
    assign sum_next = 36'(s2_prod_p_reg) + 36'(s2_prod_i_reg) + 36'(s2_prod_d_reg);

    logic signed [35:0] s3_sum_reg;
    pdd_pkg::speed_t    s3_floor_reg;

    always_ff @(posedge clk) begin
        if (s3_en && s2_valid_reg) begin
            s3_sum_reg   <= sum_next;
            s3_floor_reg <= s2_floor_reg;
        end
    end

    // ---------------- stage 4: |PID| = |sum| * 100 ----------------
    logic        sum_neg;
    logic [35:0] sum_abs;
    logic [40:0] mag_next;

    assign sum_neg  = s3_sum_reg[35];
    assign sum_abs  = sum_neg ? 36'(-s3_sum_reg) : 36'(s3_sum_reg);
    // 100 = 64 + 32 + 4
    assign mag_next = (41'(sum_abs) << 6) + (41'(sum_abs) << 5) + (41'(sum_abs) << 2);

    logic [40:0]     s4_mag_reg;
    logic            s4_neg_reg;
    pdd_pkg::speed_t s4_floor_reg;

    always_ff @(posedge clk) begin
        if (s4_en && s3_valid_reg) begin
            s4_mag_reg   <= mag_next;
            s4_neg_reg   <= sum_neg;
            s4_floor_reg <= s3_floor_reg;
        end
    end

    // ---------------- stage 5: slowed wheel and result register ----------------
    logic signed [41:0] slow_q16;    // top_speed - |PID|, Q16.16
    logic signed [41:0] floor_q16;
    logic               round_up;    // truncate toward zero on negatives
    pdd_pkg::speed_t    slowed;
    pdd_pkg::speed_t    full;

    assign slow_q16  = $signed({18'd0, top_speed_reg, 16'd0}) - $signed({1'b0, s4_mag_reg});
    assign floor_q16 = $signed({{17{s4_floor_reg[8]}}, s4_floor_reg, 16'd0});
    assign round_up  = slow_q16[41] && (slow_q16[15:0] != 16'd0);
    assign full      = $signed({1'b0, top_speed_reg});

    always_comb begin
        if (slow_q16 <= floor_q16) begin
            slowed = s4_floor_reg;
        end
        else begin
            slowed = $signed(slow_q16[24:16] + {8'd0, round_up});
        end
    end

    pdd_pkg::speed_t left_reg, right_reg;

    // Zero correction takes the positive path: left wheel slowed.
    always_ff @(posedge clk) begin
        if (out_en && s4_valid_reg) begin
            left_reg  <= s4_neg_reg ? full   : slowed;
            right_reg <= s4_neg_reg ? slowed : full;
        end
    end

    assign command.valid       = out_valid_reg;
    assign command.left_speed  = left_reg;
    assign command.right_speed = right_reg;

endmodule

`default_nettype wire

### tb/pid_differential_drive_test.sv
// Self-checking testbench for pid_differential_drive: directed and random samples,
// random config phases, a scoreboard that predicts each wheel-speed item.
// Depends on pdd_pkg, pdd_sample_if, pdd_command_if, pdd_cfg_if and the RTL.
`default_nettype none

module pid_differential_drive_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 100;   // long receiver stall
    localparam int DRAIN_CYCLES = 8;
    localparam int PID_SCALE    = 100;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 190;

    typedef struct packed {
        pdd_pkg::speed_t left;
        pdd_pkg::speed_t right;
    } wheel_pair_t;

    // Predicts the wheel commands and holds those not yet seen on the output.
    class steering_scoreboard;
        pdd_pkg::gain_t kp_set [2];   // index 0 normal set, 1 map set
        pdd_pkg::gain_t ki_set [2];
        pdd_pkg::gain_t kd_set [2];
        logic           map_mode;
        pdd_pkg::top_t  full_speed;
        int             integ_acc;
        int             last_err;
        int             errors;
        wheel_pair_t    expected [$];

        function new();
            for (int i = 0; i < 2; i++)
            begin
                kp_set[i] = '0;
                ki_set[i] = '0;
                kd_set[i] = '0;
            end
            map_mode   = 1'b0;
            full_speed = '0;
            integ_acc  = 0;
            last_err   = 0;
            errors     = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        function void set_register(pdd_pkg::cfg_index_t idx, pdd_pkg::cfg_data_t data);
            case (idx)
                pdd_pkg::REG_PROP_GAIN:      kp_set[0] = data;
                pdd_pkg::REG_INTEG_GAIN:     ki_set[0] = data;
                pdd_pkg::REG_DERIV_GAIN:     kd_set[0] = data;
                pdd_pkg::REG_MAP_PROP_GAIN:  kp_set[1] = data;
                pdd_pkg::REG_MAP_INTEG_GAIN: ki_set[1] = data;
                pdd_pkg::REG_MAP_DERIV_GAIN: kd_set[1] = data;
                pdd_pkg::REG_FOLLOW_MAP:     map_mode = data[0];
                pdd_pkg::REG_TOP_SPEED:      full_speed = data[7:0];
                default: ;
            endcase
        endfunction

        // Speed of the wheel that gets slowed, Q16.16 math, floored.
        function pdd_pkg::speed_t slowed_speed(longint mag, int floor_v);
            longint s;
            s = longint'(full_speed) * 65536 - mag;
            if (s <= longint'(floor_v) * 65536)
                return pdd_pkg::speed_t'(floor_v);
            return pdd_pkg::speed_t'(s / 65536);   // SV division truncates toward zero
        endfunction

        function void note_sample(pdd_pkg::error_t err_in, pdd_pkg::speed_t floor_in);
            int          err;
            int          floor_v;
            int          delta;
            int          sel;
            longint      pid;
            wheel_pair_t w;
            err     = err_in;
            floor_v = floor_in;
            sel     = map_mode ? 1 : 0;

            integ_acc += err;
            if (err == 0)
                integ_acc = 0;
            if (integ_acc > pdd_pkg::INTEG_LIMIT)
                integ_acc = pdd_pkg::INTEG_LIMIT;
            else if (integ_acc < -pdd_pkg::INTEG_LIMIT)
                integ_acc = -pdd_pkg::INTEG_LIMIT;

            delta    = err - last_err;
            last_err = err;

            pid = (longint'(kp_set[sel]) * err + longint'(ki_set[sel]) * integ_acc
                   + longint'(kd_set[sel]) * delta) * PID_SCALE;

            if (err >= pdd_pkg::BIG_ERROR || err <= -pdd_pkg::BIG_ERROR)
                floor_v = pdd_pkg::BIG_ERROR_FLOOR;

            if (pid >= 0)
            begin
                w.left  = slowed_speed(pid, floor_v);
                w.right = pdd_pkg::speed_t'({1'b0, full_speed});
            end
            else
            begin
                w.left  = pdd_pkg::speed_t'({1'b0, full_speed});
                w.right = slowed_speed(-pid, floor_v);
            end
            expected.push_back(w);
        endfunction

        task check_command(pdd_pkg::speed_t left_got, pdd_pkg::speed_t right_got);
            wheel_pair_t w;
            if (expected.size() == 0)
            begin
                report_mismatch($sformatf("command item with no sample waiting (L=%0d R=%0d)",
                                          left_got, right_got));
                return;
            end
            w = expected.pop_front();
            if (left_got !== w.left)
                report_mismatch($sformatf("left_speed %0d, predicted %0d", left_got, w.left));
            if (right_got !== w.right)
                report_mismatch($sformatf("right_speed %0d, predicted %0d", right_got, w.right));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pdd_sample_if  sample_ch ();
    pdd_command_if command_ch ();
    pdd_cfg_if     cfg_ch ();

    pid_differential_drive uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .command (command_ch),
        .cfg     (cfg_ch)
    );

    steering_scoreboard sb = new();

    // Sender pacing state: items left in the current burst, and whether
    // sample.valid is currently high.
    int burst_left    = 5;
    bit offering      = 1'b0;
    bit hold_request  = 1'b0;
    int idle_cycles   = 0;

    always #5ns clk = ~clk;

    // Monitor: note inputs before checking outputs, so a same-edge pair
    // never looks like an orphan result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                sb.note_sample(sample_ch.position_error, sample_ch.floor_speed);
            if (command_ch.valid && command_ch.ready)
                sb.check_command(command_ch.left_speed, command_ch.right_speed);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_register(cfg_ch.index, cfg_ch.data);
        end
    end

    // Watchdog: any handshake resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (command_ch.valid && command_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: segments of always-ready, random, periodic and mostly-stalled
    // back-pressure; a hold request forces one long stall.
    initial
    begin
        int mode;
        int seg_left;
        int cyc;
        mode     = 0;
        seg_left = 0;
        cyc      = 0;
        command_ch.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                command_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(50, 300);
                end
                seg_left--;
                cyc++;
                case (mode)
                    0: command_ch.ready <= 1'b1;
                    1: command_ch.ready <= ($urandom_range(0, 99) < 70);
                    2: command_ch.ready <= ((cyc % 4) != 3);
                    default: command_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one item and wait for it to be taken; bursts end with a gap.
    task send_item(input pdd_pkg::error_t err, input pdd_pkg::speed_t floor_v);
        sample_ch.valid          <= 1'b1;
        sample_ch.position_error <= err;
        sample_ch.floor_speed    <= floor_v;
        offering = 1'b1;
        do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            sample_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                                     : $urandom_range(1, 30);
        end
    endtask

    // Stop offering and wait until every predicted item has come out.
    task drain_results();
        if (offering)
        begin
            sample_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task write_register(input pdd_pkg::cfg_index_t idx, input pdd_pkg::cfg_data_t data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    endtask

    // Writes all eight registers; only called with the pipeline empty.
    task load_settings(input pdd_pkg::cfg_data_t settings [8]);
        for (int i = 0; i < 8; i++)
            write_register(pdd_pkg::cfg_index_t'(i), settings[i]);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int a_err [4];
        int a_flr [4];
        int b_err [15];
        int b_flr [15];
        int c_err [5];
        int c_flr [5];
        pdd_pkg::cfg_data_t settings [8];
        int err;
        int flr;
        int pick;

        // Reset values: all gains zero, top speed zero. Covers the zero
        // correction path and a floor above the top speed.
        a_err = '{0, 32767, -32768, 1};
        a_flr = '{0, 255, -255, 5};
        // Gains Kp 1.0, Ki 1/16, Kd 0.5: integral clear on zero error, integral
        // clamp, the large-error floor on both sides of the threshold, tiny errors.
        b_err = '{256, 256, -256, 0, 0, 14079, 14080, -14080, -14081,
                  32767, 32767, -32768, 1, -1, 128};
        b_flr = '{0, 0, 0, 0, 0, -255, 0, 10, -5, 0, 0, 0, 0, -255, 255};
        // Full-scale map gains: slowed wheels land on their floor but at zero error.
        c_err = '{1, -1, 0, 20000, -20000};
        c_flr = '{-255, 100, 0, 255, -1};

        sample_ch.valid          <= 1'b0;
        sample_ch.position_error <= '0;
        sample_ch.floor_speed    <= '0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.index             <= pdd_pkg::REG_PROP_GAIN;
        cfg_ch.data              <= '0;
        rst_n                    <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        for (int i = 0; i < 4; i++)
            send_item(pdd_pkg::error_t'(a_err[i]), pdd_pkg::speed_t'(a_flr[i]));
        drain_results();

        settings[pdd_pkg::REG_PROP_GAIN]      = 16'h0100;
        settings[pdd_pkg::REG_INTEG_GAIN]     = 16'h0010;
        settings[pdd_pkg::REG_DERIV_GAIN]     = 16'h0080;
        settings[pdd_pkg::REG_MAP_PROP_GAIN]  = 16'h0200;
        settings[pdd_pkg::REG_MAP_INTEG_GAIN] = 16'h0000;
        settings[pdd_pkg::REG_MAP_DERIV_GAIN] = 16'h0040;
        settings[pdd_pkg::REG_FOLLOW_MAP]     = 16'h0000;
        settings[pdd_pkg::REG_TOP_SPEED]      = 16'd200;
        load_settings(settings);
        for (int i = 0; i < 15; i++)
            send_item(pdd_pkg::error_t'(b_err[i]), pdd_pkg::speed_t'(b_flr[i]));
        drain_results();

        // Upper data bits set on the narrow registers: they must be dropped.
        settings[pdd_pkg::REG_MAP_PROP_GAIN]  = 16'hFFFF;
        settings[pdd_pkg::REG_MAP_INTEG_GAIN] = 16'hFFFF;
        settings[pdd_pkg::REG_MAP_DERIV_GAIN] = 16'hFFFF;
        settings[pdd_pkg::REG_FOLLOW_MAP]     = 16'hFFFF;
        settings[pdd_pkg::REG_TOP_SPEED]      = 16'hABFF;
        load_settings(settings);
        for (int i = 0; i < 5; i++)
            send_item(pdd_pkg::error_t'(c_err[i]), pdd_pkg::speed_t'(c_flr[i]));
        drain_results();

        // Random phases. Phase 2 uses all-max gains, phase 5 all-zero gains;
        // the rest mostly realistic small gains with an occasional wide one.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                if (p == 2)
                    settings[i] = 16'hFFFF;
                else if (p == 5)
                    settings[i] = 16'h0000;
                else if ($urandom_range(0, 3) == 0)
                    settings[i] = pdd_pkg::cfg_data_t'($urandom_range(0, 65535));
                else
                    settings[i] = pdd_pkg::cfg_data_t'($urandom_range(0, 1023));
            end
            settings[pdd_pkg::REG_FOLLOW_MAP] = pdd_pkg::cfg_data_t'($urandom_range(0, 65535));
            if (p == 2 || p == 5)
                settings[pdd_pkg::REG_TOP_SPEED] = {8'($urandom), 8'hFF};
            else
                settings[pdd_pkg::REG_TOP_SPEED] =
                    pdd_pkg::cfg_data_t'($urandom_range(0, 65535));
            load_settings(settings);

            // Long output stall with the sender pushing: fills the pipe.
            if (p == 3)
            begin
                hold_request = 1'b1;
                burst_left   = 200;
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 6 && n == PHASE_ITEMS / 2)
                    drain_results();
                pick = $urandom_range(0, 9);
                case (pick)
                    0: err = 0;
                    1: err = int'($urandom_range(0, 65535)) - 32768;
                    2:
                    begin
                        // around the large-error threshold
                        err = $urandom_range(14070, 14090);
                        if ($urandom_range(0, 1))
                            err = -err;
                    end
                    3:
                    begin
                        // big swings that push the integral into its clamp
                        err = $urandom_range(8000, 32767);
                        if ($urandom_range(0, 1))
                            err = -err;
                    end
                    default: err = int'($urandom_range(0, 1536)) - 768;
                endcase
                flr = int'($urandom_range(0, 510)) - 255;
                send_item(pdd_pkg::error_t'(err), pdd_pkg::speed_t'(flr));
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
